// ----- src/ipbf_pkg.sv -----
// ----------------------------------------------------------------------------
// ipbf_pkg
// shared types and constants of the ipv4 source blacklist packet filter
// ----------------------------------------------------------------------------
package ipbf_pkg;

   localparam int TBL_DEPTH = 1024;
   localparam int IDX_W     = $clog2(TBL_DEPTH);
   localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
   localparam int ADDR_W    = 32;
   localparam int POS_W     = 6;

   localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]       PROTO_TCP      = 8'd6;
   localparam logic [15:0]      WATCH_PORT     = 16'd4222;
   localparam logic [POS_W-1:0] LEN_ETH        = 6'd14;
   localparam logic [POS_W-1:0] LEN_IPV4       = 6'd34;
   localparam logic [POS_W-1:0] LEN_TCP        = 6'd54;
   localparam logic [POS_W-1:0] COUNT_MAX      = 6'd63;

   typedef enum logic [1:0] {
      CMD_FRAME  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_PASS     = 3'd0,
      STS_DROP     = 3'd1,
      STS_ADDED    = 3'd2,
      STS_PRESENT  = 3'd3,
      STS_FULL     = 3'd4,
      STS_REMOVED  = 3'd5,
      STS_NOTFOUND = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN
   } state_type;

endpackage

// ----- src/ipbf_req_if.sv -----
// ----------------------------------------------------------------------------
// ipbf_req_if
// request channel: frame bytes and blacklist commands
// ----------------------------------------------------------------------------
interface ipbf_req_if;
   import ipbf_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [7:0]          frame_byte;
   logic                frame_last;
   logic [ADDR_W-1:0]   table_address;

   modport source (output valid, cmd, frame_byte, frame_last, table_address, input ready);
   modport sink   (input valid, cmd, frame_byte, frame_last, table_address, output ready);
endinterface

// ----- src/ipbf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ipbf_rsp_if
// response channel: verdicts and command status
// ----------------------------------------------------------------------------
interface ipbf_rsp_if;
   import ipbf_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

// ----- src/ipv4_blacklist_packet_filter_core.sv -----
// ----------------------------------------------------------------------------
// ipv4_blacklist_packet_filter_core
// frame header capture, blacklist table in one ram, pass or drop verdict
// ----------------------------------------------------------------------------
// Frame bytes that are not last, and the reserved command, are taken without
// a table scan, as is a last byte unless the frame needs a blacklist
// lookup (normal mode, ipv4, at least 34 bytes); the lookup, and every
// insert or remove, scans the table ram one entry a cycle and stops early
// on a match. After reset a clearing pass walks every entry of the ram
// before the first request is taken; csr writes are taken throughout. A
// waiting response holds off the next request until the cycle it is taken.
module ipv4_blacklist_packet_filter_core (
   input  logic          clock,
   input  logic          reset,
   ipbf_req_if.sink      req_if,
   ipbf_rsp_if.source    rsp_if,
   input  logic          csr_we,
   input  logic          csr_wdata
);
   import ipbf_pkg::*;

   // table ram: valid bit on top of the address
   logic [ADDR_W:0] mem [TBL_DEPTH];
   logic [ADDR_W:0] rd_ff;
   logic            wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ADDR_W:0] wr_data;
   logic [IDX_W-1:0] rd_addr;

   state_type state_ff, state_in;
   cmd_type   op_ff, op_in;
   logic            panic_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W:0]   scan_idx_ff, scan_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic             rsp_vld_ff, rsp_vld_in;
   status_type       rsp_sts_ff, rsp_sts_in;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       etype_ff, etype_in;
   logic [7:0]        proto_ff, proto_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [15:0]       sport_ff, sport_in;
   logic [15:0]       dport_ff, dport_in;

   logic [15:0]       etype_c, sport_c, dport_c;
   logic [7:0]        proto_c;
   logic [ADDR_W-1:0] src_c;
   logic [POS_W-1:0]  len_c;
   logic              ipv4_c, panic_ok_c;
   logic              accept, hit, scan_end;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_if.ready);
   assign rsp_if.valid  = rsp_vld_ff;
   assign rsp_if.status = rsp_sts_ff;

   // header capture at the current byte position
   always_comb begin
      etype_c = etype_ff;
      proto_c = proto_ff;
      src_c   = src_ff;
      sport_c = sport_ff;
      dport_c = dport_ff;
      if (pos_ff == 6'd12 || pos_ff == 6'd13) begin
         etype_c = {etype_ff[7:0], req_if.frame_byte};
      end else if (pos_ff == 6'd23) begin
         proto_c = req_if.frame_byte;
      end else if (pos_ff >= 6'd26 && pos_ff <= 6'd29) begin
         src_c = {src_ff[ADDR_W-9:0], req_if.frame_byte};
      end else if (pos_ff == 6'd34 || pos_ff == 6'd35) begin
         sport_c = {sport_ff[7:0], req_if.frame_byte};
      end else if (pos_ff == 6'd36 || pos_ff == 6'd37) begin
         dport_c = {dport_ff[7:0], req_if.frame_byte};
      end
      len_c = (pos_ff < COUNT_MAX) ? pos_ff + 6'd1 : pos_ff;
      ipv4_c = (len_c >= LEN_ETH) && (etype_c == ETHERTYPE_IPV4);
      panic_ok_c = ipv4_c && (len_c >= LEN_TCP) && (proto_c == PROTO_TCP) &&
                   (dport_c == WATCH_PORT || sport_c == WATCH_PORT);
   end

   assign hit      = pend_vld_ff && rd_ff[ADDR_W] && (rd_ff[ADDR_W-1:0] == key_ff);
   assign scan_end = pend_vld_ff && (pend_idx_ff == IDX_W'(TBL_DEPTH - 1));
   assign rd_addr  = scan_idx_ff[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      pend_vld_in = 1'b0;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      key_in      = key_ff;
      clr_idx_in  = clr_idx_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_if.ready;
      rsp_sts_in  = rsp_sts_ff;
      pos_in      = pos_ff;
      etype_in    = etype_ff;
      proto_in    = proto_ff;
      src_in      = src_ff;
      sport_in    = sport_ff;
      dport_in    = dport_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_idx_ff;
      wr_data     = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(TBL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               scan_idx_in = '0;
               free_vld_in = 1'b0;
               key_in      = req_if.table_address;
               op_in       = req_if.cmd;
               case (req_if.cmd)
                  CMD_FRAME: begin
                     if (req_if.frame_last) begin
                        pos_in   = '0;
                        etype_in = '0;
                        proto_in = '0;
                        src_in   = '0;
                        sport_in = '0;
                        dport_in = '0;
                        if (panic_ff) begin
                           rsp_vld_in = 1'b1;
                           rsp_sts_in = panic_ok_c ? STS_PASS : STS_DROP;
                        end else if (!ipv4_c || len_c < LEN_IPV4) begin
                           rsp_vld_in = 1'b1;
                           rsp_sts_in = STS_PASS;
                        end else begin
                           key_in   = src_c;
                           state_in = S_SCAN;
                        end
                     end else begin
                        pos_in   = len_c;
                        etype_in = etype_c;
                        proto_in = proto_c;
                        src_in   = src_c;
                        sport_in = sport_c;
                        dport_in = dport_c;
                     end
                  end
                  CMD_INSERT, CMD_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!scan_idx_ff[IDX_W]) begin
               pend_vld_in = 1'b1;
               scan_idx_in = scan_idx_ff + (IDX_W+1)'(1);
            end
            if (pend_vld_ff && !rd_ff[ADDR_W] && !free_vld_ff) begin
               free_vld_in = 1'b1;
               free_idx_in = pend_idx_ff;
            end
            if (hit || scan_end) begin
               state_in    = S_IDLE;
               pend_vld_in = 1'b0;
               rsp_vld_in  = 1'b1;
               case (op_ff)
                  CMD_INSERT: begin
                     if (hit) begin
                        rsp_sts_in = STS_PRESENT;
                     end else if (count_ff == CNT_W'(TBL_DEPTH)) begin
                        rsp_sts_in = STS_FULL;
                     end else begin
                        rsp_sts_in = STS_ADDED;
                        count_in   = count_ff + CNT_W'(1);
                        wr_en      = 1'b1;
                        wr_addr    = free_vld_in ? free_idx_in : pend_idx_ff;
                        wr_data    = {1'b1, key_ff};
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit) begin
                        rsp_sts_in = STS_REMOVED;
                        count_in   = count_ff - CNT_W'(1);
                        wr_en      = 1'b1;
                        wr_addr    = pend_idx_ff;
                        wr_data    = '0;
                     end else begin
                        rsp_sts_in = STS_NOTFOUND;
                     end
                  end
                  default: begin
                     rsp_sts_in = hit ? STS_DROP : STS_PASS;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_idx_ff  <= '0;
         count_ff    <= '0;
         panic_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         pos_ff      <= '0;
         etype_ff    <= '0;
         proto_ff    <= '0;
         src_ff      <= '0;
         sport_ff    <= '0;
         dport_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_idx_ff  <= clr_idx_in;
         count_ff    <= count_in;
         rsp_vld_ff  <= rsp_vld_in;
         pend_vld_ff <= pend_vld_in;
         pos_ff      <= pos_in;
         etype_ff    <= etype_in;
         proto_ff    <= proto_in;
         src_ff      <= src_in;
         sport_ff    <= sport_in;
         dport_ff    <= dport_in;
         if (csr_we) begin
            panic_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= scan_idx_ff[IDX_W-1:0];
      free_vld_ff <= free_vld_in;
      free_idx_ff <= free_idx_in;
      key_ff      <= key_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

endmodule

// ----- src/ipbf_checker.sv -----
// ----------------------------------------------------------------------------
// ipbf_checker
// port level checks of the packet filter core
// ----------------------------------------------------------------------------
module ipbf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input ipbf_pkg::cmd_type   req_cmd,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ipbf_pkg::status_type rsp_status
);
   import ipbf_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // clearing pass after reset
   a_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // a byte that is not last, or a reserved command, gives no response
   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_cmd == CMD_FRAME && !req_last) || req_cmd == CMD_RSVD)
      |=> !rsp_valid)
      else $error("unexpected response");

   // a table command is never answered at once; its response waits for the scan
   a_cmd_sts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_INSERT || req_cmd == CMD_REMOVE)
      |=> !rsp_valid)
      else $error("table command answered too early");

endmodule

bind ipv4_blacklist_packet_filter_core ipbf_checker u_ipbf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .req_cmd    (req_if.cmd),
   .req_last   (req_if.frame_last),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status)
);
